FILE: rtl/swm_pkg.sv
`default_nettype none

package swm_pkg;

    localparam int DEF_MAX_WINDOW  = 64;
    localparam int DEF_SAMPLE_BITS = 32;

    localparam int WIN_SIZE_BITS   = 7;
    localparam logic [WIN_SIZE_BITS-1:0] WIN_SIZE_RESET = 7'd3;

    localparam int SAMPLE_W        = 32;
    localparam int MEDIAN_W        = 33;
    localparam int M_TDATA_W       = 40;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic accept;   // latch item, read oldest history entry
        logic update;   // reorder sorted cells, write history
        logic emit;     // load result register
    } t_dp_cmd;

    typedef struct packed {
        logic result;   // window full after this update
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: rtl/swm_ctrl.sv
`default_nettype none

module swm_ctrl
    import swm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_valid,
    output logic         o_s_ready,
    output logic         o_m_valid,
    input  wire logic    i_m_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_m_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_state = i_sts.result ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_ready    = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                o_s_ready    = 1'b1;
                o_cmd.accept = i_s_valid;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit   = w_out_free;
            end
            default: begin
                o_s_ready    = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_valid = r_out_valid;

    a_accept_to_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == S_UPDATE))
        else $error("accepted item not followed by update");

    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (!r_out_valid || i_m_ready))
        else $error("result loaded over a pending result");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE || r_state == S_EMIT) |-> !o_cmd.accept)
        else $error("item accepted while busy");

endmodule

`default_nettype wire

FILE: rtl/swm_datapath.sv
`default_nettype none

module swm_datapath
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [WIN_SIZE_BITS-1:0] i_cfg_wdata,
    input  wire logic [SAMPLE_W-1:0]      i_sample,
    input  wire logic                     i_start,
    input  wire t_dp_cmd                  i_cmd,
    output t_dp_sts                       o_sts,
    output logic [MEDIAN_W-1:0]           o_median
);

    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SW = SAMPLE_BITS;

    logic [WIN_SIZE_BITS-1:0] r_win_size;
    logic [CW-1:0]            r_fill;
    logic [AW-1:0]            r_slot;
    logic signed [SW-1:0]     r_sample;
    logic signed [SW-1:0]     r_old;
    logic signed [SW-1:0]     r_sorted [MAX_WINDOW];
    logic [SW-1:0]            r_hist   [MAX_WINDOW];
    logic signed [MEDIAN_W-1:0] r_median;

    logic [CW-1:0]            w_k;
    logic [CW-1:0]            w_fill_clip;
    logic [CW-1:0]            w_fill_adj;
    logic [AW-1:0]            w_slot_adj;
    logic                     w_full;
    logic [CW-1:0]            w_len;
    logic [CW-1:0]            w_fill_inc;
    logic [CW-1:0]            w_slot_inc;
    logic [CW-1:0]            n_fill;
    logic [AW-1:0]            n_slot;
    logic [AW-1:0]            w_mid_hi;
    logic [AW-1:0]            w_mid_lo;
    logic signed [SW:0]       w_sum;

    logic                     w_ge_old [MAX_WINDOW];
    logic                     w_gt_s   [MAX_WINDOW];
    logic                     w_bgt    [MAX_WINDOW];
    logic signed [SW-1:0]     w_b      [MAX_WINDOW];
    logic signed [SW-1:0]     w_c      [MAX_WINDOW];

    // effective window: zero reads as one, saturate at depth
    always_comb begin
        if (r_win_size == '0) begin
            w_k = CW'(1);
        end else if (32'(r_win_size) > MAX_WINDOW) begin
            w_k = CW'(MAX_WINDOW);
        end else begin
            w_k = CW'(r_win_size);
        end
    end

    assign w_fill_clip = (r_fill > w_k) ? w_k : r_fill;
    assign w_fill_adj  = i_start ? '0 : w_fill_clip;
    assign w_slot_adj  = (i_start || (CW'(r_slot) >= w_k)) ? '0 : r_slot;

    assign w_full      = (r_fill == w_k);
    assign w_len       = w_full ? (w_k - CW'(1)) : r_fill;
    assign w_fill_inc  = r_fill + CW'(1);
    assign w_slot_inc  = CW'(r_slot) + CW'(1);
    assign n_fill      = w_full ? r_fill : w_fill_inc;
    assign n_slot      = (w_slot_inc >= w_k) ? '0 : AW'(w_slot_inc);

    assign o_sts.result = w_full || (w_fill_inc == w_k);

    // sorted cells: drop first copy of oldest (full window), insert new sample
    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(g);
        logic                 shift;
        logic                 gt_nxt;
        logic signed [SW-1:0] a_nxt;

        assign w_ge_old[g] = (r_sorted[g] >= r_old);
        assign w_gt_s[g]   = (r_sorted[g] > r_sample);

        if (g < MAX_WINDOW - 1) begin : g_nxt
            assign a_nxt  = r_sorted[g+1];
            assign gt_nxt = w_gt_s[g+1];
        end else begin : g_top
            assign a_nxt  = r_sorted[g];
            assign gt_nxt = 1'b1;
        end

        assign shift    = w_full && w_ge_old[g];
        assign w_b[g]   = shift ? a_nxt : r_sorted[g];
        assign w_bgt[g] = (IDX >= w_len) || (shift ? gt_nxt : w_gt_s[g]);

        if (g == 0) begin : g_first
            assign w_c[g] = w_bgt[g] ? r_sample : w_b[g];
        end else begin : g_rest
            assign w_c[g] = !w_bgt[g] ? w_b[g] : (w_bgt[g-1] ? w_b[g-1] : r_sample);
        end
    end

    assign w_mid_hi = AW'(w_k >> 1);
    assign w_mid_lo = AW'((w_k - CW'(1)) >> 1);

    always_comb begin
        w_sum = (SW+1)'(r_sorted[w_mid_hi]) + (SW+1)'(r_sorted[w_mid_lo]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_size <= WIN_SIZE_RESET;
            r_fill     <= '0;
            r_slot     <= '0;
        end else if (i_cfg_we) begin
            r_win_size <= i_cfg_wdata;
            r_fill     <= '0;
            r_slot     <= '0;
        end else if (i_cmd.accept) begin
            r_fill     <= w_fill_adj;
            r_slot     <= w_slot_adj;
        end else if (i_cmd.update) begin
            r_fill     <= n_fill;
            r_slot     <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample[SW-1:0];
            r_old    <= r_hist[w_slot_adj];
        end
        if (i_cmd.update) begin
            r_hist[r_slot] <= r_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            for (int i = 0; i < MAX_WINDOW; i++) begin
                r_sorted[i] <= w_c[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_median <= MEDIAN_W'($unsigned(w_sum));
        end
    end

    assign o_median = r_median;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg_we |=> (r_fill <= w_k))
        else $error("fill count beyond window");

    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && !i_cfg_we) |=> (CW'(r_slot) < w_k))
        else $error("history slot beyond window");

    a_update_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && !w_full && !i_cfg_we) |=> (r_fill == $past(r_fill) + CW'(1)))
        else $error("fill count did not advance while filling");

endmodule

`default_nettype wire

FILE: rtl/sliding_window_median.sv
// Channel  Dir  Handshake                     Payload
// s_axis   in   s_axis_tvalid/s_axis_tready   tdata: sample[31:0]; tuser: start_req
// m_axis   out  m_axis_tvalid/m_axis_tready   tdata: median_twice[32:0], zero pad to 40
// cfg      in   i_cfg_we                      i_cfg_wdata: window_size[6:0]
//
// An item passes through accept and history read, then one sorted-cell
// compare-and-shift pass; when it gives a result, the median add into the output
// register follows. The emit cycle waits while an earlier result is still held.
// Synchronous active-low reset; window size returns to 3 and the window empties.

`default_nettype none

module sliding_window_median
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [WIN_SIZE_BITS-1:0] i_cfg_wdata,   // window_size
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [SAMPLE_W-1:0]      s_axis_tdata,  // sample
    input  wire logic                     s_axis_tuser,  // start_req
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic [M_TDATA_W-1:0]          m_axis_tdata   // median_twice, zero pad
);

    t_dp_cmd              w_cmd;
    t_dp_sts              w_sts;
    logic [MEDIAN_W-1:0]  w_median;

    swm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    swm_datapath #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    (s_axis_tdata),
        .i_start     (s_axis_tuser),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_median    (w_median)
    );

    assign m_axis_tdata = M_TDATA_W'(w_median);

endmodule

`default_nettype wire

FILE: tb/sv/swm_checker.sv
module swm_checker
    import swm_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [WIN_SIZE_BITS-1:0] i_cfg_wdata,   // window_size
    input  wire logic                     i_s_tvalid,
    input  wire logic                     i_s_tready,
    input  wire logic [SAMPLE_W-1:0]      i_s_tdata,     // sample
    input  wire logic                     i_s_tuser,     // start_req
    input  wire logic                     i_m_tvalid,
    input  wire logic                     i_m_tready,
    input  wire logic [M_TDATA_W-1:0]     i_m_tdata,     // median_twice, zero pad
    output int                            o_fail_count,
    output int                            o_due_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [WIN_SIZE_BITS-1:0] win_reg;
    logic [6:0]               fill_cnt;
    logic [5:0]               slot;
    logic signed [SAMPLE_W-1:0] hist       [DEF_MAX_WINDOW];
    logic signed [SAMPLE_W-1:0] sorted_win [DEF_MAX_WINDOW];
    logic [MEDIAN_W-1:0]      median_due [$];
    logic [MEDIAN_W-1:0]      want_median;
    int                       fail_cnt = 0;

    assign o_fail_count = fail_cnt;

    task automatic report_mismatch(input string what);
        $display("%0t ERROR %s", $time, what);
        fail_cnt++;
    endtask

    task automatic sorted_insert(input int n, input logic signed [SAMPLE_W-1:0] val);
        int i;
        i = n;
        while (i > 0 && sorted_win[i-1] > val) begin
            sorted_win[i] = sorted_win[i-1];
            i--;
        end
        sorted_win[i] = val;
    endtask

    task automatic predict_median(input logic signed [SAMPLE_W-1:0] smp,
                                  input logic new_series);
        int k;
        int pos;
        logic signed [SAMPLE_W-1:0] oldest;
        logic signed [MEDIAN_W-1:0] sum;
        k = (win_reg == 0) ? 1 :
            (win_reg > DEF_MAX_WINDOW) ? DEF_MAX_WINDOW : int'(win_reg);
        if (new_series) begin
            fill_cnt = '0;
            slot     = '0;
        end
        if (slot >= k) slot = '0;
        if (fill_cnt > k) fill_cnt = 7'(k);
        if (fill_cnt < k) begin
            hist[slot] = smp;
            sorted_insert(fill_cnt, smp);
            fill_cnt++;
        end else begin
            // drop one copy of the oldest sample, then insert the new one
            oldest = hist[slot];
            pos = k - 1;
            for (int i = 0; i < k; i++) begin
                if (sorted_win[i] == oldest) begin
                    pos = i;
                    break;
                end
            end
            for (int i = pos; i + 1 < k; i++) sorted_win[i] = sorted_win[i+1];
            sorted_insert(k - 1, smp);
            hist[slot] = smp;
        end
        slot++;
        if (slot >= k) slot = '0;
        if (fill_cnt == k) begin
            sum = sorted_win[k/2] + sorted_win[(k-1)/2];
            median_due.insert(median_due.size(), sum);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win_reg  = WIN_SIZE_RESET;
            fill_cnt = '0;
            slot     = '0;
            median_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (median_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result item %h", i_m_tdata));
                end else begin
                    want_median = median_due.pop_front();
                    if (i_m_tdata !== {{(M_TDATA_W-MEDIAN_W){1'b0}}, want_median})
                        report_mismatch($sformatf("median_twice got %h want %h",
                                                  i_m_tdata, want_median));
                end
            end
            if (i_cfg_we) begin
                win_reg  = i_cfg_wdata;
                fill_cnt = '0;
                slot     = '0;
            end
            if (i_s_tvalid && i_s_tready) predict_median(i_s_tdata, i_s_tuser);
        end
        o_due_count <= median_due.size();
    end

endmodule

FILE: tb/sv/tb_sliding_window_median.sv
module tb_sliding_window_median
    import swm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [WIN_SIZE_BITS-1:0] cfg_wdata;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [SAMPLE_W-1:0]      s_tdata;
    logic                     s_tuser;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [M_TDATA_W-1:0]     m_tdata;
    logic                     hold_armed;
    int                       hold_left = 300;
    int                       send_idle_pct = 0;
    int                       recv_idle_pct = 0;
    int                       fail_count;
    int                       due_count;

    sliding_window_median u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    swm_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_due_count  (due_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off once armed
    always @(posedge clk) begin
        if (hold_armed && hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(input logic [SAMPLE_W-1:0] smp, input logic new_series);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= new_series;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (due_count != 0);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_window(input logic [WIN_SIZE_BITS-1:0] w);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input int budget);
        int sent;
        int k;
        int seg_len;
        logic [WIN_SIZE_BITS-1:0] w;
        logic [SAMPLE_W-1:0] smp;
        logic new_series;
        sent = 0;
        while (sent < budget) begin
            case ($urandom_range(15))
                0:        w = 7'd0;
                1:        w = 7'd1;
                2, 3:     w = 7'd2;
                4, 5:     w = 7'd3;
                6, 7, 8:  w = 7'($urandom_range(4, 9));
                9, 10:    w = 7'($urandom_range(10, 24));
                11:       w = 7'($urandom_range(25, 63));
                12:       w = 7'd64;
                13:       w = 7'd127;
                14:       w = 7'($urandom_range(65, 126));
                default:  w = 7'($urandom_range(1, 5));
            endcase
            k = (w == 0) ? 1 : (w > DEF_MAX_WINDOW) ? DEF_MAX_WINDOW : int'(w);
            seg_len = $urandom_range(k + 4, 3 * k + 16);
            write_window(w);
            for (int j = 0; j < seg_len && sent < budget; j++) begin
                new_series = (j == 0) ? 1'($urandom_range(1)) : ($urandom_range(39) == 0);
                case ($urandom_range(9))
                    0, 1, 2, 3: smp = $urandom;
                    4, 5, 6:    smp = 32'($urandom_range(6) - 3);
                    7: begin
                        case ($urandom_range(3))
                            0:       smp = 32'h7fff_ffff;
                            1:       smp = 32'h8000_0000;
                            2:       smp = 32'h0000_0000;
                            default: smp = 32'hffff_ffff;
                        endcase
                    end
                    default:    smp = $urandom & 32'h8000_00ff;
                endcase
                send_item(smp, new_series);
                sent++;
            end
        end
    endtask

    initial begin
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_wdata  <= '0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= 1'b0;
        hold_armed <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset window of three: extremes, equal samples, full-range sums
        send_item(32'h7fff_ffff, 1'b1);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h0000_0000, 1'b0);
        send_item(32'hffff_ffff, 1'b0);
        send_item(32'h0000_0001, 1'b0);
        send_item(32'd5, 1'b1);
        send_item(32'd5, 1'b0);
        send_item(32'd5, 1'b0);
        send_item(32'h8000_0000, 1'b1);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h7fff_ffff, 1'b0);
        send_item(32'h7fff_ffff, 1'b0);
        send_item(32'h7fff_ffff, 1'b0);

        // zero window behaves as one
        write_window(7'd0);
        send_item(32'h8000_0000, 1'b1);
        send_item(32'h7fff_ffff, 1'b0);

        // even window, then a new series started over a full window
        write_window(7'd2);
        send_item(32'h7fff_ffff, 1'b1);
        send_item(32'h7fff_ffff, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'd3, 1'b0);
        send_item(32'd9, 1'b1);
        send_item(32'd11, 1'b0);

        send_idle_pct = 38;
        recv_idle_pct = 70;
        run_phase(230);
        send_idle_pct = 70;
        recv_idle_pct = 38;
        run_phase(230);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(230);

        // long receiver hold-off while the sender keeps offering
        write_window(7'd3);
        hold_armed <= 1'b1;
        for (int j = 0; j < 40; j++) send_item($urandom, j == 0);

        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && due_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
